// File: design/es2c_pkg.sv
// Shared types, constants and helpers for the epoch-seconds to calendar converter.
package es2c_pkg;

  // Default input width and the widths that follow from the fixed field ranges
  localparam int SECONDS_WIDTH_DEF = 32;
  localparam int ERA_SECS_W        = 34;  // seconds in 400 years need 34 bits
  localparam int OUT_DATA_W        = 48;  // 46 field bits padded to whole bytes

  // Calendar constants, in seconds
  localparam longint unsigned SECS_PER_ERA = 64'd12_622_780_800;  // 146097 days
  localparam int SECS_LEAP_YEAR   = 31_622_400;
  localparam int SECS_COMMON_YEAR = 31_536_000;
  localparam int SECS_MONTH_31    = 2_678_400;
  localparam int SECS_MONTH_30    = 2_592_000;
  localparam int SECS_MONTH_29    = 2_505_600;
  localparam int SECS_MONTH_28    = 2_419_200;
  localparam int SECS_PER_DAY     = 86400;
  localparam int SECS_PER_HOUR    = 3600;
  localparam int SECS_PER_MIN     = 60;
  localparam int DAYS_PER_WEEK    = 7;

  // Counters at the epoch (1970-01-01, a Thursday)
  localparam logic [7:0] EPOCH_YS1900   = 8'd70;
  localparam logic [7:0] ERA_YS_STEP    = 8'd144;  // 400 modulo 256
  localparam logic [1:0] EPOCH_Y4       = 2'd2;
  localparam logic [6:0] EPOCH_Y100     = 7'd70;
  localparam logic [8:0] EPOCH_Y400     = 9'd370;
  localparam logic [6:0] LAST_Y100      = 7'd99;
  localparam logic [8:0] LAST_Y400      = 9'd399;
  localparam logic [2:0] EPOCH_WEEK_DAY = 3'd4;

  // Month codes used by the month walk
  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_NOV = 4'd10;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  // Operand selection of the shared subtractor
  typedef enum logic [2:0] {
    OP_ERA   = 3'd0,
    OP_YEAR  = 3'd1,
    OP_MONTH = 3'd2,
    OP_DAY   = 3'd3,
    OP_HOUR  = 3'd4,
    OP_MIN   = 3'd5
  } alu_op_e;

  // Control from the sequencer to the subtractor
  typedef struct packed {
    alu_op_e    op;
    logic       leap;
    logic [3:0] month;
  } alu_ctl_t;

  // One calendar result
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] month_day;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [8:0] year_day;
    logic [2:0] week_day;
  } cal_t;

  // Length of a month in days
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Length of a month in seconds
  function automatic logic [21:0] month_secs(input logic [3:0] month, input logic leap);
    logic [21:0] secs;
    unique case (month)
      MONTH_FEB: secs = leap ? 22'(SECS_MONTH_29) : 22'(SECS_MONTH_28);
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: secs = 22'(SECS_MONTH_30);
      default: secs = 22'(SECS_MONTH_31);
    endcase
    return secs;
  endfunction

  // Weekday advance of a whole month: its length modulo 7
  function automatic logic [1:0] month_wd_step(input logic [3:0] month, input logic leap);
    return 2'(month_len(month, leap) - 5'd28);
  endfunction

  // Advance a weekday by up to three days, wrapping at a week
  function automatic logic [2:0] week_day_add(input logic [2:0] wd, input logic [1:0] step);
    logic [3:0] sum;
    sum = {1'b0, wd} + {2'b00, step};
    return (sum >= 4'(DAYS_PER_WEEK)) ? 3'(sum - 4'(DAYS_PER_WEEK)) : sum[2:0];
  endfunction

endpackage

// File: design/epoch_seconds_to_calendar.sv
// Operation: skips whole 400-year spans, then steps whole years, whole months, and whole days,
//   hours and minutes off the input, each by repeated subtraction, then moves the result into
//   the output register.
// Throughput: one item at a time; the single shared subtractor does every step, and the next
//   item is taken the cycle after the previous result moves into the output register.
// Reset: asynchronous, active low; clears the sequencer and the output valid, no clearing pass.
module epoch_seconds_to_calendar #(
  parameter int SECONDS_WIDTH = es2c_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // epoch_seconds
  input  logic [((SECONDS_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // second, minute, hour, month_day, month_index, years_since_1900, year_day, week_day
  output logic [es2c_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import es2c_pkg::*;

  logic                  seq_res_valid, seq_res_ready;
  cal_t                  seq_res;
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  es2c_seq #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .secs_i      (s_axis_tdata[SECONDS_WIDTH-1:0]),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res)
  );

  // Output register takes a result when empty or being drained
  assign seq_res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (seq_res_ready) begin
      m_valid_q <= seq_res_valid;
    end
  end

  // Pack the fields, first field lowest
  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      m_data_q <= {2'b00, seq_res.week_day, seq_res.year_day, seq_res.years_since_1900,
                   seq_res.month_index, seq_res.month_day, seq_res.hour,
                   seq_res.minute, seq_res.second};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Sequencer never takes an item while a result is pending
  a_idle_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && seq_res_valid))
    else $error("sequencer ready while holding a result");

  // An accepted item makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block ready right after accepting an item");

  // A handed-off result shows up on the output
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res_valid && seq_res_ready |=> m_axis_tvalid)
    else $error("result lost on handoff");

  // Delivered fields stay inside their calendar ranges
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5:0] < 6'd60) && (m_axis_tdata[11:6] < 6'd60)
      && (m_axis_tdata[16:12] < 5'd24) && (m_axis_tdata[21:17] != 5'd0)
      && (m_axis_tdata[25:22] < 4'd12) && (m_axis_tdata[42:34] <= 9'd365)
      && (m_axis_tdata[45:43] < 3'd7))
    else $error("calendar field out of range");

endmodule

// File: design/es2c_alu.sv
// Shared subtract-and-compare unit with operand selection for every sequencer step.
module es2c_alu #(
  parameter int ALU_W = es2c_pkg::ERA_SECS_W
) (
  input  es2c_pkg::alu_ctl_t ctl_i,
  input  logic [ALU_W-1:0]   a_i,
  output logic [ALU_W-1:0]   diff_o,
  output logic               ge_o
);
  import es2c_pkg::*;

  logic [ALU_W-1:0] b;
  logic [ALU_W:0]   full;

  // Select the subtrahend for the current step, in seconds
  always_comb begin
    unique case (ctl_i.op)
      OP_ERA:   b = ALU_W'(SECS_PER_ERA);
      OP_YEAR:  b = ctl_i.leap ? ALU_W'(SECS_LEAP_YEAR) : ALU_W'(SECS_COMMON_YEAR);
      OP_MONTH: b = ALU_W'(month_secs(ctl_i.month, ctl_i.leap));
      OP_DAY:   b = ALU_W'(SECS_PER_DAY);
      OP_HOUR:  b = ALU_W'(SECS_PER_HOUR);
      OP_MIN:   b = ALU_W'(SECS_PER_MIN);
      default:  b = '0;
    endcase
  end

  // Subtract; no borrow means a is at least b
  assign full   = {1'b0, a_i} - {1'b0, b};
  assign diff_o = full[ALU_W-1:0];
  assign ge_o   = ~full[ALU_W];

endmodule

// File: design/es2c_seq.sv
// Sequencer: era, year, month, day, hour and minute walks on the shared subtractor.
module es2c_seq #(
  parameter int SECONDS_WIDTH = es2c_pkg::SECONDS_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SECONDS_WIDTH-1:0] secs_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output es2c_pkg::cal_t           res_o
);
  import es2c_pkg::*;

  localparam int ALU_W = (SECONDS_WIDTH > ERA_SECS_W) ? SECONDS_WIDTH : ERA_SECS_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_ERA   = 8'b00000010,
    S_YEAR  = 8'b00000100,
    S_MONTH = 8'b00001000,
    S_DAY   = 8'b00010000,
    S_HOUR  = 8'b00100000,
    S_MIN   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e           state_q, state_d;
  logic [ALU_W-1:0] secs_q, secs_d;
  logic [7:0]       ys_q, ys_d;
  logic [1:0]       y4_q, y4_d;
  logic [6:0]       y100_q, y100_d;
  logic [8:0]       y400_q, y400_d;
  logic [3:0]       month_q, month_d;
  cal_t             res_q, res_d;
  logic             leap;

  alu_ctl_t         ctl;
  logic [ALU_W-1:0] alu_diff;
  logic             alu_ge;

  es2c_alu #(.ALU_W(ALU_W)) u_alu (
    .ctl_i  (ctl),
    .a_i    (secs_q),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  // Gregorian leap rule from the year residues
  assign leap = ((y4_q == 2'd0) && (y100_q != 7'd0)) || (y400_q == 9'd0);

  // Drive the shared unit
  always_comb begin
    ctl.leap  = leap;
    ctl.month = month_q;
    unique case (state_q)
      S_ERA:   ctl.op = OP_ERA;
      S_MONTH: ctl.op = OP_MONTH;
      S_DAY:   ctl.op = OP_DAY;
      S_HOUR:  ctl.op = OP_HOUR;
      S_MIN:   ctl.op = OP_MIN;
      default: ctl.op = OP_YEAR;
    endcase
  end

  // Next state and datapath: subtract each unit while the remaining seconds cover it
  always_comb begin
    state_d = state_q;
    secs_d  = secs_q;
    ys_d    = ys_q;
    y4_d    = y4_q;
    y100_d  = y100_q;
    y400_d  = y400_q;
    month_d = month_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          secs_d            = ALU_W'(secs_i);
          ys_d              = EPOCH_YS1900;
          y4_d              = EPOCH_Y4;
          y100_d            = EPOCH_Y100;
          y400_d            = EPOCH_Y400;
          month_d           = MONTH_JAN;
          res_d.week_day    = EPOCH_WEEK_DAY;
          res_d.year_day    = '0;
          res_d.month_day   = 5'd1;
          res_d.hour        = '0;
          res_d.minute      = '0;
          state_d           = S_ERA;
        end
      end
      S_ERA: begin
        // Skip whole 400-year cycles; the residues and the weekday repeat
        if (alu_ge) begin
          secs_d = alu_diff;
          ys_d   = ys_q + ERA_YS_STEP;
        end else begin
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        if (alu_ge) begin
          secs_d         = alu_diff;
          ys_d           = ys_q + 8'd1;
          y4_d           = y4_q + 2'd1;
          y100_d         = (y100_q == LAST_Y100) ? 7'd0 : y100_q + 7'd1;
          y400_d         = (y400_q == LAST_Y400) ? 9'd0 : y400_q + 9'd1;
          res_d.week_day = week_day_add(res_q.week_day, leap ? 2'd2 : 2'd1);
        end else begin
          res_d.years_since_1900 = ys_q;
          state_d                = S_MONTH;
        end
      end
      S_MONTH: begin
        // December takes whatever is left of the year
        if ((month_q >= MONTH_DEC) || !alu_ge) begin
          res_d.month_index = month_q;
          state_d           = S_DAY;
        end else begin
          secs_d         = alu_diff;
          month_d        = month_q + 4'd1;
          res_d.week_day = week_day_add(res_q.week_day, month_wd_step(month_q, leap));
          res_d.year_day = res_q.year_day + {4'b0000, month_len(month_q, leap)};
        end
      end
      S_DAY: begin
        if (alu_ge) begin
          secs_d          = alu_diff;
          res_d.month_day = res_q.month_day + 5'd1;
          res_d.year_day  = res_q.year_day + 9'd1;
          res_d.week_day  = week_day_add(res_q.week_day, 2'd1);
        end else begin
          state_d = S_HOUR;
        end
      end
      S_HOUR: begin
        if (alu_ge) begin
          secs_d     = alu_diff;
          res_d.hour = res_q.hour + 5'd1;
        end else begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (alu_ge) begin
          secs_d       = alu_diff;
          res_d.minute = res_q.minute + 6'd1;
        end else begin
          res_d.second = secs_q[5:0];
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    secs_q  <= secs_d;
    ys_q    <= ys_d;
    y4_q    <= y4_d;
    y100_q  <= y100_d;
    y400_q  <= y400_d;
    month_q <= month_d;
    res_q   <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// File: verif/tb.sv
// Testbench for epoch_seconds_to_calendar: directed and random epoch counts vs. a predictor.
`timescale 1ns / 100ps

module tb;
  import es2c_pkg::*;

  localparam int          IN_W          = 32;
  localparam int unsigned DAY_SECS      = 86400;
  localparam int unsigned HOUR_SECS     = 3600;
  localparam int unsigned MIN_SECS      = 60;
  localparam int unsigned FIRST_YEAR    = 1970;
  localparam int unsigned BASE_YEAR     = 1900;
  localparam int unsigned EPOCH_WEEKDAY = 4;   // 1970-01-01 was a Thursday
  localparam int          RANDOM_ITEMS  = 1230;
  localparam int          SETTLE_CYCLES = 300; // idle time after the drain, before the verdict
  localparam int          IDLE_PCT      = 36;
  localparam int          REPORT_LIMIT  = 10;

  // One calendar breakdown, second in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic [2:0] week_day;
    logic [8:0] year_day;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] month_day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_fields_t;

  // One epoch count to send; after_drain holds it until no date is outstanding
  typedef struct {
    logic [IN_W-1:0] secs;
    bit              after_drain;
  } epoch_item_t;

  logic            clk_i  = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [47:0]     m_tdata;

  epoch_item_t  pending_secs[$];
  date_fields_t expected_dates[$];
  int           seconds_sent = 0;
  int           dates_seen   = 0;
  int           mismatches   = 0;

  epoch_seconds_to_calendar #(
    .SECONDS_WIDTH(IN_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // epoch_seconds
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)    // second, minute, hour, month_day, month_index,
                                // years_since_1900, year_day, week_day
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Break an epoch count into its UTC calendar fields
  function automatic date_fields_t to_calendar(input logic [IN_W-1:0] secs);
    date_fields_t r;
    int unsigned  days, sod, yr, mon, mlen, ylen;
    bit           leap;
    days = secs / DAY_SECS;
    sod  = secs % DAY_SECS;
    r.hour     = 5'(sod / HOUR_SECS);
    r.minute   = 6'((sod % HOUR_SECS) / MIN_SECS);
    r.second   = 6'((sod % HOUR_SECS) % MIN_SECS);
    r.week_day = 3'((days + EPOCH_WEEKDAY) % 7);
    // walk whole years
    yr   = FIRST_YEAR;
    leap = leap_year(yr);
    ylen = leap ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      leap = leap_year(yr);
      ylen = leap ? 366 : 365;
    end
    r.year_day = 9'(days);
    // walk months; December takes whatever is left
    mon = 0;
    forever begin
      case (4'(mon))
        MONTH_FEB: mlen = leap ? 29 : 28;
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: mlen = 30;
        default: mlen = 31;
      endcase
      if (4'(mon) >= MONTH_DEC || days < mlen) break;
      days -= mlen;
      mon++;
    end
    r.month_day        = 5'(days + 1);
    r.month_index      = 4'(mon);
    r.years_since_1900 = 8'(yr - BASE_YEAR);
    return r;
  endfunction

  function automatic void add_epoch(input longint unsigned s, input bit after_drain = 1'b0);
    epoch_item_t it;
    it.secs        = IN_W'(s);
    it.after_drain = after_drain;
    pending_secs.push_back(it);
  endfunction

  // Feed the slave side; predict each date as its transfer completes
  always @(posedge clk_i) begin : drive_proc
    logic            nxt_valid;
    logic [IN_W-1:0] nxt_data;
    bit              gap;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        expected_dates.push_back(to_calendar(s_tdata));
        seconds_sent++;
        nxt_valid = 1'b0;
      end
      gap = !(seconds_sent >= 400 && seconds_sent < 650) && ($urandom_range(99) < IDLE_PCT);
      if (!nxt_valid && !gap && pending_secs.size() > 0) begin
        if (!pending_secs[0].after_drain || expected_dates.size() == 0) begin
          nxt_data  = pending_secs[0].secs;
          nxt_valid = 1'b1;
          void'(pending_secs.pop_front());
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  function automatic void report_mismatch(input string why, input date_fields_t want,
                                          input date_fields_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t mismatch, %s: want y%0d m%0d d%0d %0d:%0d:%0d yd%0d wd%0d",
               $realtime, why,
               want.years_since_1900, want.month_index, want.month_day, want.hour,
               want.minute, want.second, want.year_day, want.week_day);
      $display("    got y%0d m%0d d%0d %0d:%0d:%0d yd%0d wd%0d",
               got.years_since_1900, got.month_index, got.month_day, got.hour,
               got.minute, got.second, got.year_day, got.week_day);
    end
  endfunction

  // Check master-side transfers and stall the result stream at random
  always @(posedge clk_i) begin : watch_proc
    date_fields_t got, want;
    bit           bad;
    if (rst_ni && m_tvalid && m_tready) begin
      got = date_fields_t'(m_tdata[45:0]);
      dates_seen++;
      if (expected_dates.size() == 0) begin
        report_mismatch("date with nothing pending", got, got);
      end else begin
        want = expected_dates.pop_front();
        bad = (got.second != want.second) || (got.minute != want.minute) ||
              (got.hour != want.hour) || (got.month_day != want.month_day) ||
              (got.month_index != want.month_index) ||
              (got.years_since_1900 != want.years_since_1900) ||
              (got.year_day != want.year_day) || (got.week_day != want.week_day);
        if (bad) report_mismatch("field differs", want, got);
      end
    end
    m_tready <= (dates_seen >= 380 && dates_seen < 700) || ($urandom_range(99) >= IDLE_PCT);
  end

  // Stimulus, drain and verdict
  initial begin : main_proc
    longint unsigned s, d;
    int              pick;
    // day, hour and minute edges at the epoch
    add_epoch(0);
    add_epoch(59);
    add_epoch(60);
    add_epoch(3599);
    add_epoch(3600);
    add_epoch(86399);
    add_epoch(86400);
    // end of July and first of August 1970
    add_epoch(64'd18230400);
    add_epoch(64'd18316800);
    // last second of 1970, first of 1971
    add_epoch(64'd31535999, 1'b1);
    add_epoch(64'd31536000);
    // leap day and last day of the leap year 1972
    add_epoch(64'd68169600);
    add_epoch(64'd94608000);
    // century leap year 2000: Feb 29 and Dec 31
    add_epoch(64'd951782400);
    add_epoch(64'd978220800 + 86399);
    // signed 32-bit rollover
    add_epoch(64'd2147483647);
    add_epoch(64'd2147483648);
    // 2100 is not a leap year: Feb 28 then Mar 1
    add_epoch(64'd4107456000);
    add_epoch(64'd4107542400);
    // top of the input range and alternating bit patterns
    add_epoch(64'hFFFF_FFFF);
    add_epoch(64'hFFFF_FFFE);
    add_epoch(64'hAAAA_AAAA);
    add_epoch(64'h5555_5555);

    // random counts, weighted toward day edges and the ends of the range
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        s = $urandom;
      end else if (pick < 70) begin
        d = $urandom_range(49709);
        case ($urandom_range(3))
          0: s = d * DAY_SECS;
          1: s = d * DAY_SECS + DAY_SECS - 1;
          2: s = d * DAY_SECS + HOUR_SECS * $urandom_range(23);
          default: s = d * DAY_SECS + $urandom_range(DAY_SECS - 1);
        endcase
      end else if (pick < 90) begin
        s = $urandom_range(100_000_000);
      end else begin
        s = 64'hFFFF_FFFF - $urandom_range(10_000_000);
      end
      add_epoch(s, (i % 300) == 150);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_secs.size() > 0 || s_tvalid || expected_dates.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog_proc
    #(64'd10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
